>>> rtl/v3n_pkg.sv
// shared types and constants for the three-axis vector normalizer
package v3n_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int UNIT_FRAC_DEF    = 14;
    localparam int LEN_FRAC         = 8;
    localparam int FIELD_WIDTH      = 16;
    localparam int LEN_WIDTH        = 24;
    localparam int AXES             = 3;

    localparam logic [31:0]          UNIT_POS_MAX = 32'd32767;
    localparam logic [31:0]          UNIT_NEG_MAG = 32'd32768;
    localparam logic [LEN_WIDTH-1:0] LEN_MAX      = {LEN_WIDTH{1'b1}};

    // per-request control that travels with the data down the cell row
    typedef struct packed {
        logic            valid;
        logic            zero;
        logic [AXES-1:0] neg;
    } v3n_ctrl_t;

    // finished result as it sits in the output stage
    typedef struct packed {
        logic [AXES-1:0][FIELD_WIDTH-1:0] unit;
        logic [LEN_WIDTH-1:0]             length;
        logic                             zero_vector;
    } v3n_result_t;

endpackage

>>> rtl/vector3_normalize_core.sv
// path from accept to out_valid: front registers, square root cells, division cells, output register
// throughput: one request per cycle; one row of cells, one square root bit or one
//   quotient bit per cell, all three axes side by side in each division cell
// the whole row moves together and holds only while the skid entry is full
// reset (rst_n, async, active low) empties the row and the output stage; no clearing pass
module vector3_normalize_core #(
    parameter int SAMPLE_WIDTH   = v3n_pkg::SAMPLE_WIDTH_DEF,
    parameter int UNIT_FRAC_BITS = v3n_pkg::UNIT_FRAC_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [v3n_pkg::FIELD_WIDTH-1:0] in_x,
    input  logic signed [v3n_pkg::FIELD_WIDTH-1:0] in_y,
    input  logic signed [v3n_pkg::FIELD_WIDTH-1:0] in_z,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [v3n_pkg::FIELD_WIDTH-1:0] unit_x,
    output logic signed [v3n_pkg::FIELD_WIDTH-1:0] unit_y,
    output logic signed [v3n_pkg::FIELD_WIDTH-1:0] unit_z,
    output logic        [v3n_pkg::LEN_WIDTH-1:0]   length,
    output logic                                  zero_vector
);
    import v3n_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int SUMW  = 2 * SW;                      // sum of squares never reaches 2^SUMW
    localparam int RW    = SW + LEN_FRAC;               // scaled length width
    localparam int QW    = UNIT_FRAC_BITS + 1;          // quotient never exceeds 2^UNIT_FRAC_BITS
    localparam int SHIFT = UNIT_FRAC_BITS + LEN_FRAC;
    localparam int DIVN  = SW + SHIFT;                  // quotient bits per axis
    localparam int LW    = (RW > LEN_WIDTH) ? RW : LEN_WIDTH;

    // whole row advances unless the skid entry is occupied
    logic advance;
    assign in_stall = !advance;

    // ---------------------------------------------------------------
    // front: sign split, squares, sum
    // ---------------------------------------------------------------
    logic [SW-1:0] raw     [AXES];
    logic [SW-1:0] mag     [AXES];
    logic [AXES-1:0] neg;

    // only the low SW bits of each sample count, taken as two's complement
    assign raw[0] = SW'($unsigned(in_x));
    assign raw[1] = SW'($unsigned(in_y));
    assign raw[2] = SW'($unsigned(in_z));

    for (genvar a = 0; a < AXES; a++) begin : g_split
        assign neg[a] = raw[a][SW-1];
        assign mag[a] = neg[a] ? (~raw[a] + 1'b1) : raw[a];
    end

    v3n_ctrl_t     a_ctrl_reg;
    logic [SW-1:0] a_mag_reg [AXES];
    v3n_ctrl_t     b_ctrl_reg;
    logic [SW-1:0] b_mag_reg [AXES];
    logic [SUMW-1:0] b_sq_reg [AXES];
    v3n_ctrl_t     c_ctrl_reg;
    logic [SW-1:0] c_mag_reg [AXES];
    logic [SUMW-1:0] c_sum_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            a_ctrl_reg <= '0;
            b_ctrl_reg <= '0;
            c_ctrl_reg <= '0;
        end
        else if (advance)
        begin
            a_ctrl_reg.valid <= in_valid;
            a_ctrl_reg.zero  <= (raw[0] == '0) && (raw[1] == '0) && (raw[2] == '0);
            a_ctrl_reg.neg   <= neg;
            b_ctrl_reg       <= a_ctrl_reg;
            c_ctrl_reg       <= b_ctrl_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (advance)
        begin
            a_mag_reg <= mag;
            for (int a = 0; a < AXES; a++)
            begin
                b_sq_reg[a] <= SUMW'(a_mag_reg[a]) * SUMW'(a_mag_reg[a]);
            end
            b_mag_reg <= a_mag_reg;
            c_sum_reg <= b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
            c_mag_reg <= b_mag_reg;
        end
    end

    // ---------------------------------------------------------------
    // square root row: floor(sqrt(sum) * 2^LEN_FRAC), msb first
    // ---------------------------------------------------------------
    v3n_ctrl_t       sq_ctrl [RW+1];
    logic [SUMW-1:0] sq_sum  [RW+1];
    logic [SW-1:0]   sq_mag  [RW+1][AXES];
    logic [RW-1:0]   sq_root [RW+1];
    logic [RW:0]     sq_rem  [RW+1];

    assign sq_ctrl[0] = c_ctrl_reg;
    assign sq_sum[0]  = c_sum_reg;
    assign sq_mag[0]  = c_mag_reg;
    assign sq_root[0] = '0;
    assign sq_rem[0]  = '0;

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        v3n_sqrt_cell #(
            .SW   (SW),
            .RW   (RW),
            .STEP (RW - 1 - k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (advance),
            .ctrl_in  (sq_ctrl[k]),
            .sum_in   (sq_sum[k]),
            .mag_in   (sq_mag[k]),
            .root_in  (sq_root[k]),
            .rem_in   (sq_rem[k]),
            .ctrl_out (sq_ctrl[k+1]),
            .sum_out  (sq_sum[k+1]),
            .mag_out  (sq_mag[k+1]),
            .root_out (sq_root[k+1]),
            .rem_out  (sq_rem[k+1])
        );
    end

    // ---------------------------------------------------------------
    // division row: mag * 2^SHIFT / length for each axis, msb first
    // ---------------------------------------------------------------
    v3n_ctrl_t     dv_ctrl [DIVN+1];
    logic [RW-1:0] dv_len  [DIVN+1];
    logic [SW-1:0] dv_mag  [DIVN+1][AXES];
    logic [RW-1:0] dv_rem  [DIVN+1][AXES];
    logic [QW-1:0] dv_q    [DIVN+1][AXES];

    assign dv_ctrl[0] = sq_ctrl[RW];
    assign dv_len[0]  = sq_root[RW];
    assign dv_mag[0]  = sq_mag[RW];

    for (genvar a = 0; a < AXES; a++) begin : g_div_init
        assign dv_rem[0][a] = '0;
        assign dv_q[0][a]   = '0;
    end

    for (genvar k = 0; k < DIVN; k++) begin : g_div
        v3n_div_cell #(
            .SW    (SW),
            .RW    (RW),
            .QW    (QW),
            .SHIFT (SHIFT),
            .STEP  (DIVN - 1 - k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (advance),
            .ctrl_in  (dv_ctrl[k]),
            .len_in   (dv_len[k]),
            .mag_in   (dv_mag[k]),
            .rem_in   (dv_rem[k]),
            .q_in     (dv_q[k]),
            .ctrl_out (dv_ctrl[k+1]),
            .len_out  (dv_len[k+1]),
            .mag_out  (dv_mag[k+1]),
            .rem_out  (dv_rem[k+1]),
            .q_out    (dv_q[k+1])
        );
    end

    // ---------------------------------------------------------------
    // pack: sign, saturation to 16 bits, length clamp, zero vector
    // ---------------------------------------------------------------
    v3n_result_t   pipe_data;
    v3n_result_t   out_data;
    logic [31:0]   q_wide [AXES];
    logic [LW-1:0] len_wide;

    assign len_wide = LW'(dv_len[DIVN]);

    always_comb begin
        pipe_data = '0;
        for (int a = 0; a < AXES; a++)
        begin
            q_wide[a] = 32'(dv_q[DIVN][a]);
            if (dv_ctrl[DIVN].neg[a])
            begin
                if (q_wide[a] > UNIT_NEG_MAG)
                begin
                    pipe_data.unit[a] = FIELD_WIDTH'(0 - UNIT_NEG_MAG);
                end
                else
                begin
                    pipe_data.unit[a] = FIELD_WIDTH'(0 - q_wide[a]);
                end
            end
            else
            begin
                if (q_wide[a] > UNIT_POS_MAX)
                begin
                    pipe_data.unit[a] = FIELD_WIDTH'(UNIT_POS_MAX);
                end
                else
                begin
                    pipe_data.unit[a] = FIELD_WIDTH'(q_wide[a]);
                end
            end
        end
        pipe_data.length = (len_wide > LW'(LEN_MAX)) ? LEN_MAX : LEN_WIDTH'(len_wide);
        // an all-zero sample skips the division result entirely
        if (dv_ctrl[DIVN].zero)
        begin
            pipe_data.unit   = '0;
            pipe_data.length = '0;
        end
        pipe_data.zero_vector = dv_ctrl[DIVN].zero;
    end

    v3n_out_skid u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .pipe_valid (dv_ctrl[DIVN].valid),
        .pipe_data  (pipe_data),
        .pipe_ready (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    assign unit_x      = $signed(out_data.unit[0]);
    assign unit_y      = $signed(out_data.unit[1]);
    assign unit_z      = $signed(out_data.unit[2]);
    assign length      = out_data.length;
    assign zero_vector = out_data.zero_vector;

    // root of a nonzero sum is at least one whole unit, root of zero is zero
    a_root_matches_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dv_ctrl[DIVN].valid |-> ((dv_len[DIVN] == '0) == dv_ctrl[DIVN].zero))
        else $error("length does not agree with zero flag");

    // a zero-vector result carries nothing else
    a_zero_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_vector) |->
            (length == '0) && (unit_x == '0) && (unit_y == '0) && (unit_z == '0))
        else $error("zero vector result with nonzero fields");

    // a nonzero sample always reports a nonzero length
    a_nonzero_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !zero_vector) |-> (length != '0))
        else $error("nonzero vector with zero length");

endmodule

>>> rtl/v3n_sqrt_cell.sv
// one restoring square root step: settles one bit of the scaled length
module v3n_sqrt_cell #(
    parameter int SW   = 16,
    parameter int RW   = 24,
    parameter int STEP = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  v3n_pkg::v3n_ctrl_t   ctrl_in,
    input  logic [2*SW-1:0]      sum_in,
    input  logic [SW-1:0]        mag_in [v3n_pkg::AXES],
    input  logic [RW-1:0]        root_in,
    input  logic [RW:0]          rem_in,
    output v3n_pkg::v3n_ctrl_t   ctrl_out,
    output logic [2*SW-1:0]      sum_out,
    output logic [SW-1:0]        mag_out [v3n_pkg::AXES],
    output logic [RW-1:0]        root_out,
    output logic [RW:0]          rem_out
);
    import v3n_pkg::*;

    logic [1:0]    pair;
    logic [RW+2:0] rem_sh;
    logic [RW+2:0] trial;
    logic          ge;

    // fraction pairs below the sum are zero
    if (STEP >= LEN_FRAC) begin : g_pair
        assign pair = sum_in[2*(STEP-LEN_FRAC) +: 2];
    end else begin : g_nopair
        assign pair = 2'b00;
    end

    assign rem_sh = {rem_in, pair};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            ctrl_out <= '0;
        end
        else if (en)
        begin
            ctrl_out <= ctrl_in;
        end
    end

    always_ff @(posedge clk) begin
        if (en)
        begin
            sum_out  <= sum_in;
            mag_out  <= mag_in;
            root_out <= {root_in[RW-2:0], ge};
            rem_out  <= ge ? (RW+1)'(rem_sh - trial) : (RW+1)'(rem_sh);
        end
    end

endmodule

>>> rtl/v3n_div_cell.sv
// one restoring division step for all three axes: one quotient bit each
module v3n_div_cell #(
    parameter int SW    = 16,
    parameter int RW    = 24,
    parameter int QW    = 15,
    parameter int SHIFT = 22,
    parameter int STEP  = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  v3n_pkg::v3n_ctrl_t   ctrl_in,
    input  logic [RW-1:0]        len_in,
    input  logic [SW-1:0]        mag_in [v3n_pkg::AXES],
    input  logic [RW-1:0]        rem_in [v3n_pkg::AXES],
    input  logic [QW-1:0]        q_in   [v3n_pkg::AXES],
    output v3n_pkg::v3n_ctrl_t   ctrl_out,
    output logic [RW-1:0]        len_out,
    output logic [SW-1:0]        mag_out [v3n_pkg::AXES],
    output logic [RW-1:0]        rem_out [v3n_pkg::AXES],
    output logic [QW-1:0]        q_out   [v3n_pkg::AXES]
);
    import v3n_pkg::*;

    logic [RW:0] rem_sh  [AXES];
    logic [RW:0] len_ext;
    logic        ge      [AXES];

    assign len_ext = {1'b0, len_in};

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        // dividend bits past the magnitude are the appended zero fraction
        if (STEP >= SHIFT) begin : g_bit
            assign rem_sh[a] = {rem_in[a], mag_in[a][STEP-SHIFT]};
        end else begin : g_zero
            assign rem_sh[a] = {rem_in[a], 1'b0};
        end
        assign ge[a] = (rem_sh[a] >= len_ext);

        always_ff @(posedge clk) begin
            if (en)
            begin
                rem_out[a] <= ge[a] ? RW'(rem_sh[a] - len_ext) : RW'(rem_sh[a]);
                q_out[a]   <= {q_in[a][QW-2:0], ge[a]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            ctrl_out <= '0;
        end
        else if (en)
        begin
            ctrl_out <= ctrl_in;
        end
    end

    always_ff @(posedge clk) begin
        if (en)
        begin
            len_out <= len_in;
            mag_out <= mag_in;
        end
    end

endmodule

>>> rtl/v3n_out_skid.sv
// output register with one skid entry so the cell row can keep moving
module v3n_out_skid (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pipe_valid,
    input  v3n_pkg::v3n_result_t pipe_data,
    output logic                 pipe_ready,
    output logic                 out_valid,
    input  logic                 out_stall,
    output v3n_pkg::v3n_result_t out_data
);
    import v3n_pkg::*;

    logic        out_valid_reg;
    logic        skid_valid_reg;
    v3n_result_t out_data_reg;
    v3n_result_t skid_data_reg;
    logic        slot_free;
    logic        take;

    assign pipe_ready = !skid_valid_reg;
    assign slot_free  = !out_valid_reg || !out_stall;
    assign take       = pipe_valid && !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (slot_free)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (take)
            begin
                if (slot_free)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else
            begin
                // nothing arriving: output empties once it is taken
                if (slot_free)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (skid_valid_reg)
        begin
            if (slot_free)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (take)
        begin
            if (slot_free)
            begin
                out_data_reg <= pipe_data;
            end
            else
            begin
                skid_data_reg <= pipe_data;
            end
        end
    end

    // skid only fills behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output entry");

    // a new request behind a held output fills the skid entry and stops the row
    a_full_stops_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && take) |=> skid_valid_reg && !pipe_ready)
        else $error("skid did not capture request");

endmodule

>>> sim/testbench.sv
// self-checking testbench for vector3_normalize_core: random and corner samples, scoreboard check
`timescale 1ns / 100ps

module testbench;

    import v3n_pkg::*;

    localparam int PIPE_LATENCY = 4 + 2 * SAMPLE_WIDTH_DEF + UNIT_FRAC_DEF + 16;
    localparam int RANDOM_SAMPLES = 700;
    localparam int IDLE_PERCENT = 37;
    localparam int HOLD_CYCLES = 400;

    typedef logic signed [FIELD_WIDTH-1:0] sample_t;

    // expected unit vectors, oldest first; prediction done at accept time
    class unit_vector_scoreboard;
        v3n_result_t pending_units[$];
        int          mismatches = 0;

        // floor(sqrt(x^2 + y^2 + z^2) * 2^LEN_FRAC), components over length, truncated
        function automatic v3n_result_t unit_vector_of(sample_t x, sample_t y, sample_t z);
            sample_t         comp[AXES];
            longint unsigned mag[AXES];
            longint unsigned sum_sq;
            longint unsigned target;
            longint unsigned root;
            longint unsigned trial;
            longint unsigned quo;
            v3n_result_t     res;
            comp[0] = x;
            comp[1] = y;
            comp[2] = z;
            sum_sq = 0;
            res = '0;
            for (int k = 0; k < AXES; k++)
            begin
                mag[k] = (comp[k] < 0) ? longint'(-longint'(comp[k])) : longint'(comp[k]);
                sum_sq += mag[k] * mag[k];
            end
            if (sum_sq == 0)
            begin
                res.zero_vector = 1'b1;
                return res;
            end
            // bitwise square root of the scaled sum
            target = sum_sq << (2 * LEN_FRAC);
            root = 0;
            for (int b = 31; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= target)
                    root = trial;
            end
            for (int k = 0; k < AXES; k++)
            begin
                quo = (mag[k] << (UNIT_FRAC_DEF + LEN_FRAC)) / root;
                if (comp[k] < 0)
                begin
                    if (quo > UNIT_NEG_MAG)
                        quo = UNIT_NEG_MAG;
                    res.unit[k] = FIELD_WIDTH'(-quo);
                end
                else
                begin
                    if (quo > UNIT_POS_MAX)
                        quo = UNIT_POS_MAX;
                    res.unit[k] = FIELD_WIDTH'(quo);
                end
            end
            res.length = (root > longint'(LEN_MAX)) ? LEN_MAX : LEN_WIDTH'(root);
            return res;
        endfunction

        function void note_sample(sample_t x, sample_t y, sample_t z);
            pending_units.push_back(unit_vector_of(x, y, z));
        endfunction

        function void check_result(sample_t ux, sample_t uy, sample_t uz,
                                   logic [LEN_WIDTH-1:0] len, logic zv);
            v3n_result_t want;
            if (pending_units.size() == 0)
            begin
                $error("result with no request outstanding: unit %0d %0d %0d length %0d",
                       ux, uy, uz, len);
                mismatches++;
                return;
            end
            want = pending_units.pop_front();
            if (ux !== want.unit[0])
            begin
                $error("unit_x expected %0d actual %0d", $signed(want.unit[0]), ux);
                mismatches++;
            end
            if (uy !== want.unit[1])
            begin
                $error("unit_y expected %0d actual %0d", $signed(want.unit[1]), uy);
                mismatches++;
            end
            if (uz !== want.unit[2])
            begin
                $error("unit_z expected %0d actual %0d", $signed(want.unit[2]), uz);
                mismatches++;
            end
            if (len !== want.length)
            begin
                $error("length expected %0d actual %0d", want.length, len);
                mismatches++;
            end
            if (zv !== want.zero_vector)
            begin
                $error("zero_vector expected %0d actual %0d", want.zero_vector, zv);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_units.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    sample_t              in_x;
    sample_t              in_y;
    sample_t              in_z;
    logic                 out_valid;
    logic                 out_stall;
    sample_t              unit_x;
    sample_t              unit_y;
    sample_t              unit_z;
    logic [LEN_WIDTH-1:0] length;
    logic                 zero_vector;

    // shared between sender and receiver
    logic steady = 1'b0;
    logic hold_req = 1'b0;

    unit_vector_scoreboard sb = new();

    vector3_normalize_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_x        (in_x),
        .in_y        (in_y),
        .in_z        (in_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .unit_x      (unit_x),
        .unit_y      (unit_y),
        .unit_z      (unit_z),
        .length      (length),
        .zero_vector (zero_vector)
    );

    always #5 clk = ~clk;

    // present one request, holding it until accepted; random idle cycles ahead of it
    task automatic offer_sample(input sample_t x, input sample_t y, input sample_t z);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_x <= x;
        in_y <= y;
        in_z <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_sample(x, y, z);
    endtask

    // corner values of the sample range (extremes, zero, ones, half scale), now and then a random one
    function automatic sample_t edge_value();
        case ($urandom_range(7))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            5: return 16'sd32767;
            6: return 16'sd16384;
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic sample_t small_value();
        return sample_t'($urandom_range(16)) - 16'sd8;
    endfunction

    // sender
    initial
    begin : stimulus
        sample_t c[AXES];
        int      mode;
        int      axis;
        in_valid = 1'b0;
        in_x = '0;
        in_y = '0;
        in_z = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed corners: zero, single axes at both extremes, all-max, all-min, mixed, tiny values
        offer_sample(16'sd0, 16'sd0, 16'sd0);
        offer_sample(16'sd32767, 16'sd0, 16'sd0);
        offer_sample(-16'sd32768, 16'sd0, 16'sd0);
        offer_sample(16'sd0, 16'sd32767, 16'sd0);
        offer_sample(16'sd0, -16'sd32768, 16'sd0);
        offer_sample(16'sd0, 16'sd0, 16'sd32767);
        offer_sample(16'sd0, 16'sd0, -16'sd32768);
        offer_sample(16'sd32767, 16'sd32767, 16'sd32767);
        offer_sample(-16'sd32768, -16'sd32768, -16'sd32768);
        offer_sample(-16'sd32768, 16'sd32767, -16'sd32768);
        offer_sample(16'sd1, 16'sd0, 16'sd0);
        offer_sample(16'sd0, 16'sd0, -16'sd1);
        offer_sample(16'sd1, 16'sd1, 16'sd1);
        offer_sample(-16'sd1, -16'sd1, -16'sd1);
        offer_sample(16'sd3, 16'sd4, 16'sd0);
        offer_sample(16'sd0, -16'sd3, 16'sd4);
        offer_sample(16'sd2, -16'sd3, 16'sd6);
        offer_sample(16'sd1, -16'sd32768, 16'sd0);
        offer_sample(-16'sd32768, 16'sd1, 16'sd1);
        offer_sample(16'sd0, 16'sd0, 16'sd0);

        for (int n = 0; n < RANDOM_SAMPLES; n++)
        begin
            // long receiver hold-off at sample 250, then a stretch with no idling
            if (n == 250)
                hold_req = 1'b1;
            steady = (n >= 450 && n < 550);
            mode = $urandom_range(99);
            axis = $urandom_range(AXES - 1);
            for (int k = 0; k < AXES; k++)
            begin
                if (mode < 40)
                    c[k] = sample_t'($urandom);
                else if (mode < 55)
                    c[k] = small_value();
                else if (mode < 70)
                    c[k] = (k == axis) ? sample_t'($urandom) : small_value();
                else if (mode < 85)
                    c[k] = edge_value();
                else if (mode < 95)
                    c[k] = sample_t'($urandom) >>> $urandom_range(15);
                else
                    c[k] = '0;
            end
            offer_sample(c[0], c[1], c[2]);
        end
        steady = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        // drain, then watch a little longer for stray results
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 20) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request, quiet while steady
    initial
    begin : sink
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (steady)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(unit_x, unit_y, unit_z, length, zero_vector);
    end

    initial
    begin : watchdog
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> vector3_normalize_core.f
rtl/v3n_pkg.sv
rtl/v3n_sqrt_cell.sv
rtl/v3n_div_cell.sv
rtl/v3n_out_skid.sv
rtl/vector3_normalize_core.sv
sim/testbench.sv
